/* src/hri_pkg.sv */
// shared types and constants of the history record indexer
package hri_pkg;

    localparam int unsigned OFFSET_W = 32;
    localparam int unsigned NUMBER_W = 24;
    localparam int unsigned BYTE_W   = 8;
    localparam int unsigned SLOT_W   = 16;
    localparam int unsigned SKIP_W   = 3;
    localparam int unsigned CFG_IDX_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    // pending step codes
    localparam logic [1:0] STEP_NONE = 2'd0;
    localparam logic [1:0] STEP_UP   = 2'd1;
    localparam logic [1:0] STEP_DOWN = 2'd3;

    // skip lengths and the count at which the marker offset is latched
    localparam logic [SKIP_W-1:0] SKIP_AFTER_END = 3'd3;
    localparam logic [SKIP_W-1:0] SKIP_OLD_MARK  = 3'd4;
    localparam logic [SKIP_W-1:0] SKIP_LATCH_AT  = 3'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_START_OFFSET   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_START_INDEX    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UNDO_BYTE      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MARKER_BYTE    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FORMAT_VERSION = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_CHAR_MASK      = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_MASK      = 3'd6;

    // configuration reset values
    localparam logic [OFFSET_W-1:0] RST_START_OFFSET   = 32'd2;
    localparam logic [NUMBER_W-1:0] RST_START_INDEX    = 24'd1;
    localparam logic [BYTE_W-1:0]   RST_UNDO_BYTE      = 8'd0;
    localparam logic [BYTE_W-1:0]   RST_MARKER_BYTE    = 8'd0;
    localparam logic                RST_FORMAT_VERSION = 1'b1;
    localparam logic [BYTE_W-1:0]   RST_CHAR_MASK      = 8'hff;
    localparam logic [SLOT_W-1:0]   RST_SLOT_MASK      = 16'h001f;

    typedef struct packed {
        logic [OFFSET_W-1:0] start_offset;
        logic [NUMBER_W-1:0] start_index;
        logic [BYTE_W-1:0]   undo_byte;
        logic [BYTE_W-1:0]   marker_byte;
        logic                format_version;
        logic [BYTE_W-1:0]   char_mask;
        logic [SLOT_W-1:0]   slot_mask;
    } t_cfg;

    typedef struct packed {
        logic                entry_written;
        logic [NUMBER_W-1:0] command_number;
        logic [SLOT_W-1:0]   table_slot;
        logic [OFFSET_W-1:0] entry_offset;
        logic [OFFSET_W-1:0] marker_offset;
    } t_result;

endpackage

/* src/hri_scan.sv */
// scan state of the history record indexer and its per-byte update
module hri_scan (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [hri_pkg::BYTE_W-1:0]    i_data_byte,
    input  logic                          i_first,
    input  hri_pkg::t_cfg                 i_cfg,
    output hri_pkg::t_result              o_result
);

    logic [hri_pkg::OFFSET_W-1:0] r_byte_offset, n_byte_offset;
    logic [hri_pkg::NUMBER_W-1:0] r_current_number, n_current_number;
    logic [hri_pkg::BYTE_W-1:0]   r_previous_byte, n_previous_byte;
    logic [1:0]                   r_pending_step, n_pending_step;
    logic [hri_pkg::SKIP_W-1:0]   r_skip_left, n_skip_left;
    logic [hri_pkg::OFFSET_W-1:0] r_last_marker, n_last_marker;

    logic [hri_pkg::OFFSET_W-1:0] eff_offset;
    logic [hri_pkg::NUMBER_W-1:0] eff_number;
    logic [hri_pkg::BYTE_W-1:0]   eff_prev;
    logic [1:0]                   eff_step;
    logic [hri_pkg::SKIP_W-1:0]   eff_skip;
    logic [hri_pkg::BYTE_W-1:0]   c;
    logic                         written;

    always_comb begin
        // a first byte sees the scan reloaded from configuration
        eff_offset = i_first ? i_cfg.start_offset : r_byte_offset;
        eff_number = i_first ? i_cfg.start_index  : r_current_number;
        eff_prev   = i_first ? '0 : r_previous_byte;
        eff_step   = i_first ? hri_pkg::STEP_NONE : r_pending_step;
        eff_skip   = i_first ? '0 : r_skip_left;
        c          = i_data_byte & i_cfg.char_mask;

        n_byte_offset    = eff_offset + 32'd1;
        n_current_number = eff_number;
        n_previous_byte  = c;
        n_pending_step   = eff_step;
        n_skip_left      = eff_skip;
        n_last_marker    = r_last_marker;
        written          = 1'b0;

        if (eff_skip != '0) begin
            n_skip_left     = eff_skip - 3'd1;
            n_previous_byte = '0;
            if (n_skip_left == hri_pkg::SKIP_LATCH_AT) begin
                n_last_marker = n_byte_offset;
            end
        end else if (c == '0) begin
            // end of record
            if (eff_prev == i_cfg.marker_byte && eff_step == hri_pkg::STEP_NONE) begin
                n_skip_left = hri_pkg::SKIP_AFTER_END;
            end
            priority if (eff_step == hri_pkg::STEP_UP) begin
                n_current_number = eff_number + 24'd1;
            end else if (eff_step == hri_pkg::STEP_DOWN) begin
                n_current_number = eff_number - 24'd1;
            end else begin
                n_current_number = eff_number;
            end
            n_pending_step = hri_pkg::STEP_NONE;
            written        = 1'b1;
        end else if (eff_prev == '0) begin
            // record start: marker wins over undo
            priority if (c == i_cfg.marker_byte) begin
                if (!i_cfg.format_version) begin
                    n_skip_left = hri_pkg::SKIP_OLD_MARK;
                end
                n_pending_step = hri_pkg::STEP_NONE;
            end else if (c == i_cfg.undo_byte) begin
                n_pending_step = hri_pkg::STEP_DOWN;
            end else begin
                n_pending_step = eff_step;
            end
        end else begin
            n_pending_step = hri_pkg::STEP_UP;
        end

        o_result.entry_written  = written;
        o_result.command_number = n_current_number;
        o_result.table_slot     = n_current_number[hri_pkg::SLOT_W-1:0] & i_cfg.slot_mask;
        o_result.entry_offset   = n_byte_offset;
        o_result.marker_offset  = n_last_marker;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byte_offset    <= hri_pkg::RST_START_OFFSET;
            r_current_number <= hri_pkg::RST_START_INDEX;
            r_previous_byte  <= '0;
            r_pending_step   <= hri_pkg::STEP_NONE;
            r_skip_left      <= '0;
            r_last_marker    <= '0;
        end else if (i_accept) begin
            r_byte_offset    <= n_byte_offset;
            r_current_number <= n_current_number;
            r_previous_byte  <= n_previous_byte;
            r_pending_step   <= n_pending_step;
            r_skip_left      <= n_skip_left;
            r_last_marker    <= n_last_marker;
        end
    end

`ifndef NO_ASSERTIONS
    a_skip_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skip_left <= hri_pkg::SKIP_OLD_MARK)
        else $error("skip counter out of range");

    a_step_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pending_step != 2'd2)
        else $error("pending step holds an unused code");

    a_skip_clears_prev: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_accept && eff_skip != '0 |=> r_previous_byte == '0)
        else $error("skipped byte left a previous byte");
`endif

endmodule

/* src/history_record_indexer_top.sv */
// top level of the history record indexer: config registers, handshake, result register
//
// channel   | direction | handshake               | payload
// input     | in        | i_valid / o_stall       | i_data_byte, i_first
// result    | out       | o_valid / i_stall       | o_entry_written .. o_marker_offset
// config    | in        | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
// one byte per cycle unless stalled; a result shows in the cycle after it is accepted
// the scan update is a few adds and byte compares ahead of the result register
// a new request is taken while the result register is empty or being drained
// reset is synchronous, active low, and loads the config registers with their defaults
// a stalled result holds, and the input stalls only while that result is stuck
module history_record_indexer_top (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_stall,
    input  logic [hri_pkg::BYTE_W-1:0]       i_data_byte,
    input  logic                             i_first,
    output logic                             o_valid,
    input  logic                             i_stall,
    output logic                             o_entry_written,
    output logic [hri_pkg::NUMBER_W-1:0]     o_command_number,
    output logic [hri_pkg::SLOT_W-1:0]       o_table_slot,
    output logic [hri_pkg::OFFSET_W-1:0]     o_entry_offset,
    output logic [hri_pkg::OFFSET_W-1:0]     o_marker_offset,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [hri_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [hri_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    hri_pkg::t_cfg    r_cfg;
    hri_pkg::t_result scan_result;
    hri_pkg::t_result r_out;
    logic             r_out_valid;
    logic             accept;
    logic             cfg_write;

    assign o_stall     = r_out_valid && i_stall;
    assign accept      = i_valid && !o_stall;
    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.start_offset   <= hri_pkg::RST_START_OFFSET;
            r_cfg.start_index    <= hri_pkg::RST_START_INDEX;
            r_cfg.undo_byte      <= hri_pkg::RST_UNDO_BYTE;
            r_cfg.marker_byte    <= hri_pkg::RST_MARKER_BYTE;
            r_cfg.format_version <= hri_pkg::RST_FORMAT_VERSION;
            r_cfg.char_mask      <= hri_pkg::RST_CHAR_MASK;
            r_cfg.slot_mask      <= hri_pkg::RST_SLOT_MASK;
        end else if (cfg_write) begin
            unique case (i_cfg_index)
                hri_pkg::REG_START_OFFSET:   r_cfg.start_offset   <= i_cfg_data;
                hri_pkg::REG_START_INDEX:    r_cfg.start_index    <= i_cfg_data[23:0];
                hri_pkg::REG_UNDO_BYTE:      r_cfg.undo_byte      <= i_cfg_data[7:0];
                hri_pkg::REG_MARKER_BYTE:    r_cfg.marker_byte    <= i_cfg_data[7:0];
                hri_pkg::REG_FORMAT_VERSION: r_cfg.format_version <= i_cfg_data[0];
                hri_pkg::REG_CHAR_MASK:      r_cfg.char_mask      <= i_cfg_data[7:0];
                hri_pkg::REG_SLOT_MASK:      r_cfg.slot_mask      <= i_cfg_data[15:0];
                default: begin
                end
            endcase
        end
    end

    hri_scan u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_data_byte (i_data_byte),
        .i_first     (i_first),
        .i_cfg       (r_cfg),
        .o_result    (scan_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_out <= scan_result;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_entry_written  = r_out.entry_written;
    assign o_command_number = r_out.command_number;
    assign o_table_slot     = r_out.table_slot;
    assign o_entry_offset   = r_out.entry_offset;
    assign o_marker_offset  = r_out.marker_offset;

`ifndef NO_ASSERTIONS
    a_stall_only_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> !o_stall)
        else $error("input stalled with an empty result register");

    a_request_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_valid)
        else $error("accepted request produced no result");

    a_slot_within_mask: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (o_table_slot & ~$past(r_cfg.slot_mask)) == '0)
        else $error("table slot outside slot mask");

    a_offset_advances: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept && !i_first && $past(accept) |=>
        o_entry_offset == $past(o_entry_offset) + 32'd1)
        else $error("entry offset did not advance by one");
`endif

endmodule
